// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the battery charge block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// clocked check that also applies during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

// ----- sv/bvcp_pkg.sv -----
// ----------------------------------------------------------------------------
// bvcp_pkg
// widths, discharge curve and interpolation constants for the charge block
// ----------------------------------------------------------------------------
package bvcp_pkg;

  // field widths
  localparam int PIN_W  = 12;
  localparam int OHM_W  = 20;
  localparam int BATT_W = 16;
  localparam int PCT_W  = 7;
  localparam int PROD_W = PIN_W + OHM_W;
  localparam int REM_W  = OHM_W;
  localparam int DIV_STEPS = BATT_W;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_TOTAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_LOWER = 1'd1;
  localparam logic [OHM_W-1:0] DIV_TOTAL_RST = 20'd200000;
  localparam logic [OHM_W-1:0] DIV_LOWER_RST = 20'd100000;

  // discharge curve
  localparam int CURVE_LEN    = 21;
  localparam int TABLE_POINTS = 21;
  localparam int POINTS_CLIP  = (TABLE_POINTS > CURVE_LEN) ? CURVE_LEN : TABLE_POINTS;
  localparam int POINTS_USED  = (POINTS_CLIP < 2) ? 2 : POINTS_CLIP;
  localparam int IDX_W        = $clog2(CURVE_LEN);

  typedef logic [BATT_W-1:0] mv_t;
  typedef logic [PCT_W-1:0]  pct_t;

  localparam mv_t CURVE_MV [CURVE_LEN] = '{
    16'd4200, 16'd4150, 16'd4100, 16'd4050, 16'd4000, 16'd3950, 16'd3900,
    16'd3850, 16'd3800, 16'd3750, 16'd3700, 16'd3650, 16'd3600, 16'd3550,
    16'd3500, 16'd3450, 16'd3400, 16'd3350, 16'd3300, 16'd3200, 16'd3000
  };

  localparam pct_t CURVE_PCT [CURVE_LEN] = '{
    7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
    7'd65,  7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
    7'd30,  7'd25, 7'd20, 7'd15, 7'd10, 7'd5,  7'd0
  };

  // interpolation datapath: offset within a segment (span at most 200),
  // percent step per segment (at most 5), and the fixed-point reciprocal
  // ceil(2^RECIP_SHIFT / span) of each segment span
  localparam int OFF_W       = 8;
  localparam int DP_W        = 3;
  localparam int NUM_W       = OFF_W + DP_W;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 20;
  localparam int QP_W        = NUM_W + RECIP_W;

  typedef logic [RECIP_W-1:0] recip_t;

  localparam recip_t SEG_RECIP [CURVE_LEN-1] = '{
    15'd20972, 15'd20972, 15'd20972, 15'd20972, 15'd20972, 15'd20972,
    15'd20972, 15'd20972, 15'd20972, 15'd20972, 15'd20972, 15'd20972,
    15'd20972, 15'd20972, 15'd20972, 15'd20972, 15'd20972, 15'd20972,
    15'd10486, 15'd5243
  };

  // handoff from the divider pipe to the interpolator
  typedef struct packed {
    logic              valid;
    logic [BATT_W-1:0] batt;
  } stage_t;

endpackage

// ----- sv/bvcp_in_if.sv -----
// ----------------------------------------------------------------------------
// bvcp_in_if
// input channel: one pin voltage sample per transfer
// ----------------------------------------------------------------------------
interface bvcp_in_if
  import bvcp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIN_W-1:0] pin_millivolts;

  modport source (output valid, output pin_millivolts, input ready);
  modport sink   (input valid, input pin_millivolts, output ready);
endinterface

// ----- sv/bvcp_out_if.sv -----
// ----------------------------------------------------------------------------
// bvcp_out_if
// result channel: battery voltage and charge percent per transfer
// ----------------------------------------------------------------------------
interface bvcp_out_if
  import bvcp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BATT_W-1:0] battery_millivolts;
  logic [PCT_W-1:0]  charge_percent;

  modport source (output valid, output battery_millivolts, output charge_percent,
                  input ready);
  modport sink   (input valid, input battery_millivolts, input charge_percent,
                  output ready);
endinterface

// ----- sv/bvcp_div_pipe.sv -----
// ----------------------------------------------------------------------------
// bvcp_div_pipe
// divider scaling: pin * full / output ohms, saturated, one quotient bit/stage
// ----------------------------------------------------------------------------
module bvcp_div_pipe
  import bvcp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [PIN_W-1:0] pin,
  input  logic [OHM_W-1:0] div_total,
  input  logic [OHM_W-1:0] div_lower,
  output stage_t           result
);

  // multiply stage
  logic [PROD_W-1:0] prod_r;
  logic              prod_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else if (en) begin
      prod_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(pin) * PROD_W'(div_total);
    end
  end

  // long division stages; index 0 is the saturation check stage
  logic [REM_W-1:0]  rem_r  [DIV_STEPS+1];
  logic [BATT_W-1:0] low_r  [DIV_STEPS+1];
  logic [BATT_W-1:0] q_r    [DIV_STEPS+1];
  logic              sat_r  [DIV_STEPS+1];
  logic              vld_r  [DIV_STEPS+1];

  logic [REM_W-1:0]  rem_nxt [DIV_STEPS];
  logic [BATT_W-1:0] low_nxt [DIV_STEPS];
  logic [BATT_W-1:0] q_nxt   [DIV_STEPS];

  logic [REM_W-1:0] prod_hi;
  assign prod_hi = REM_W'(prod_r[PROD_W-1 -: (PROD_W-BATT_W)]);

  // quotient at or above 2^BATT_W (or zero divisor) saturates
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= prod_hi;
      low_r[0] <= prod_r[BATT_W-1:0];
      q_r[0]   <= '0;
      sat_r[0] <= (prod_hi >= div_lower);
    end
  end

  // one restoring step per stage
  always_comb begin
    logic [REM_W:0] trial;
    logic           ge;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial      = {rem_r[k], low_r[k][BATT_W-1]};
      ge         = (trial >= {1'b0, div_lower});
      rem_nxt[k] = ge ? REM_W'(trial - {1'b0, div_lower}) : REM_W'(trial);
      low_nxt[k] = {low_r[k][BATT_W-2:0], 1'b0};
      q_nxt[k]   = {q_r[k][BATT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_r[k+1] <= rem_nxt[k];
        low_r[k+1] <= low_nxt[k];
        q_r[k+1]   <= q_nxt[k];
        sat_r[k+1] <= sat_r[k];
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= prod_v_r;
      for (int k = 0; k < DIV_STEPS; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
    end
  end

  assign result.valid = vld_r[DIV_STEPS];
  assign result.batt  = sat_r[DIV_STEPS] ? '1 : q_r[DIV_STEPS];

endmodule

// ----- sv/bvcp_interp.sv -----
// ----------------------------------------------------------------------------
// bvcp_interp
// discharge curve lookup with integer linear interpolation, five stages
// ----------------------------------------------------------------------------
module bvcp_interp
  import bvcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  stage_t            in_stage,
  output logic              valid,
  output logic [BATT_W-1:0] batt,
  output logic [PCT_W-1:0]  pct
);

  localparam int LAST = POINTS_USED - 1;

  logic [4:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_stage.valid};
    end
  end

  // stage 1: segment search and clamp flags
  logic [BATT_W-1:0] v1_r;
  logic [IDX_W-1:0]  seg_r;
  logic              above_r;
  logic              below_r;
  logic [IDX_W-1:0]  seg_nxt;

  always_comb begin
    seg_nxt = '0;
    for (int i = 0; i < LAST; i++) begin
      if (in_stage.batt <= CURVE_MV[i]) begin
        seg_nxt = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r    <= in_stage.batt;
      seg_r   <= seg_nxt;
      above_r <= (in_stage.batt >= CURVE_MV[0]);
      below_r <= (in_stage.batt <= CURVE_MV[LAST]);
    end
  end

  // stage 2: offset into segment, step and reciprocal
  logic [BATT_W-1:0]  v2_r;
  logic [OFF_W-1:0]   off_r;
  logic [DP_W-1:0]    dp_r;
  recip_t             rc_r;
  logic [PCT_W-1:0]   pl2_r;
  logic [IDX_W-1:0]   idx_lo;
  logic [BATT_W-1:0]  diff;
  logic [PCT_W-1:0]   dp_full;

  assign idx_lo  = seg_r + 1'b1;
  assign diff    = v1_r - CURVE_MV[idx_lo];
  assign dp_full = CURVE_PCT[seg_r] - CURVE_PCT[idx_lo];

  always_ff @(posedge clk) begin
    if (en) begin
      v2_r <= v1_r;
      rc_r <= SEG_RECIP[seg_r];
      dp_r <= dp_full[DP_W-1:0];
      if (above_r) begin
        off_r <= '0;
        pl2_r <= CURVE_PCT[0];
      end else if (below_r) begin
        off_r <= '0;
        pl2_r <= CURVE_PCT[LAST];
      end else begin
        off_r <= diff[OFF_W-1:0];
        pl2_r <= CURVE_PCT[idx_lo];
      end
    end
  end

  // stage 3: offset times percent step
  logic [BATT_W-1:0] v3_r;
  logic [NUM_W-1:0]  num_r;
  recip_t            rc3_r;
  logic [PCT_W-1:0]  pl3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      v3_r  <= v2_r;
      num_r <= NUM_W'(off_r) * NUM_W'(dp_r);
      rc3_r <= rc_r;
      pl3_r <= pl2_r;
    end
  end

  // stage 4: divide by span through its reciprocal
  logic [BATT_W-1:0] v4_r;
  logic [QP_W-1:0]   qp_r;
  logic [PCT_W-1:0]  pl4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      v4_r  <= v3_r;
      qp_r  <= QP_W'(num_r) * QP_W'(rc3_r);
      pl4_r <= pl3_r;
    end
  end

  // stage 5: add to the lower point percent
  logic [BATT_W-1:0] v5_r;
  logic [PCT_W-1:0]  pct_r;

  always_ff @(posedge clk) begin
    if (en) begin
      v5_r  <= v4_r;
      pct_r <= pl4_r + PCT_W'(qp_r[QP_W-1:RECIP_SHIFT]);
    end
  end

  assign valid = vld_r[4];
  assign batt  = v5_r;
  assign pct   = pct_r;

endmodule

// ----- sv/battery_voltage_to_charge_percent_core.sv -----
// ----------------------------------------------------------------------------
// battery_voltage_to_charge_percent_core
// pin voltage to battery voltage and state of charge
// ----------------------------------------------------------------------------
// usage:
//   in_chan carries one pin voltage (mV) per transfer; out_chan returns the
//   divider-corrected battery voltage (saturated at 65535 mV) and the charge
//   percent from the discharge curve, one result per sample, in order.
//   cfg_we/cfg_index/cfg_wdata write the divider full and output resistances;
//   write them only while no sample is in flight.
// throughput: one sample per cycle, sustained while out_chan is not stalled.
// pipeline: the multiply stage, the saturation check stage and 16 one-bit
//   restoring division stages, then 5 interpolation stages and the output
//   register, lie between the input transfer and out_chan.valid.
// reset: synchronous, active low; clears all valid bits and loads the
//   resistances with 200000 and 100000 ohms.
// stall: a held result sits in the output register while one more result
//   lands in a skid register; the pipeline then freezes and in_chan.ready
//   drops until the receiver takes a result. nothing is lost or repeated.
// ----------------------------------------------------------------------------
module battery_voltage_to_charge_percent_core
  import bvcp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OHM_W-1:0]     cfg_wdata,
  bvcp_in_if.sink              in_chan,
  bvcp_out_if.source           out_chan
);

  // configuration registers
  logic [OHM_W-1:0] div_total_r;
  logic [OHM_W-1:0] div_lower_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_total_r <= DIV_TOTAL_RST;
      div_lower_r <= DIV_LOWER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIV_TOTAL: div_total_r <= cfg_wdata;
        REG_DIV_LOWER: div_lower_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline advances while the skid register is free
  logic skid_v_r;
  logic adv;

  assign adv           = !skid_v_r;
  assign in_chan.ready = adv;

  stage_t div_res;

  bvcp_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_chan.valid),
    .pin       (in_chan.pin_millivolts),
    .div_total (div_total_r),
    .div_lower (div_lower_r),
    .result    (div_res)
  );

  logic              ip_valid;
  logic [BATT_W-1:0] ip_batt;
  logic [PCT_W-1:0]  ip_pct;

  bvcp_interp u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_stage (div_res),
    .valid    (ip_valid),
    .batt     (ip_batt),
    .pct      (ip_pct)
  );

  // output register plus skid register
  logic              out_v_r, out_v_nxt;
  logic [BATT_W-1:0] out_batt_r, out_batt_nxt;
  logic [PCT_W-1:0]  out_pct_r, out_pct_nxt;
  logic              skid_v_nxt;
  logic [BATT_W-1:0] skid_batt_r, skid_batt_nxt;
  logic [PCT_W-1:0]  skid_pct_r, skid_pct_nxt;
  logic              push;
  logic              take;

  assign push = adv && ip_valid;
  assign take = out_v_r && out_chan.ready;

  always_comb begin
    out_v_nxt     = out_v_r;
    out_batt_nxt  = out_batt_r;
    out_pct_nxt   = out_pct_r;
    skid_v_nxt    = skid_v_r;
    skid_batt_nxt = skid_batt_r;
    skid_pct_nxt  = skid_pct_r;
    if (!out_v_r || take) begin
      if (skid_v_r) begin
        out_v_nxt    = 1'b1;
        out_batt_nxt = skid_batt_r;
        out_pct_nxt  = skid_pct_r;
        skid_v_nxt   = 1'b0;
      end else begin
        out_v_nxt    = push;
        out_batt_nxt = ip_batt;
        out_pct_nxt  = ip_pct;
      end
    end else if (push) begin
      skid_v_nxt    = 1'b1;
      skid_batt_nxt = ip_batt;
      skid_pct_nxt  = ip_pct;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_batt_r  <= out_batt_nxt;
    out_pct_r   <= out_pct_nxt;
    skid_batt_r <= skid_batt_nxt;
    skid_pct_r  <= skid_pct_nxt;
  end

  assign out_chan.valid              = out_v_r;
  assign out_chan.battery_millivolts = out_batt_r;
  assign out_chan.charge_percent     = out_pct_r;

endmodule

// ----- sv/bvcp_checker.sv -----
// ----------------------------------------------------------------------------
// bvcp_checker
// port-level checks on the charge block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bvcp_checker
  import bvcp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BATT_W-1:0] out_batt,
  input logic [PCT_W-1:0]  out_pct
);

  // a stalled result holds its payload
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_batt) && $stable(out_pct))

  // input backpressure only follows a receiver stall
  `ASSERT_CLK(a_ready_cause, clk, rst_n, !in_ready |-> $past(out_valid && !out_ready))

  // full charge and cutoff ends of the curve
  `ASSERT_CLK(a_full_end, clk, rst_n, out_valid && out_batt >= CURVE_MV[0] |-> out_pct == CURVE_PCT[0])
  `ASSERT_CLK(a_cut_end, clk, rst_n, out_valid && out_batt <= CURVE_MV[POINTS_USED-1] |-> out_pct == CURVE_PCT[POINTS_USED-1])

  // reset empties the result channel
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind battery_voltage_to_charge_percent_core bvcp_checker u_bvcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_batt  (out_chan.battery_millivolts),
  .out_pct   (out_chan.charge_percent)
);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for battery_voltage_to_charge_percent_core: pin voltage
// samples go in under random gaps while the result side stalls at random and
// once for a long stretch. every result is compared field by field, in order,
// against a local model of divider scaling and discharge curve interpolation.
// the divider resistances are rewritten between phases while the pipe is empty
// ----------------------------------------------------------------------------
module tb;
  import bvcp_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int PIPE_LATENCY = 24;
  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_COUNT  = 10;
  localparam int PHASE_ITEMS  = 90;

  // one expected result
  typedef struct {
    mv_t  batt;
    pct_t pct;
  } reading_t;

  // predicts each reading and matches results against it, oldest first
  class charge_scoreboard;
    logic [OHM_W-1:0] div_total;
    logic [OHM_W-1:0] div_lower;
    reading_t         expected_readings[$];
    int               errors;

    function new();
      div_total = DIV_TOTAL_RST;
      div_lower = DIV_LOWER_RST;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [OHM_W-1:0] val);
      if (idx == REG_DIV_TOTAL) div_total = val;
      else if (idx == REG_DIV_LOWER) div_lower = val;
    endfunction

    // pin voltage scaled by the divider ratio, truncated and saturated
    function mv_t scale_pin(logic [PIN_W-1:0] pin);
      longint unsigned prod;
      if (div_lower == '0) return '1;
      prod = (longint'(pin) * longint'(div_total)) / longint'(div_lower);
      if (prod > 65535) return '1;
      return mv_t'(prod);
    endfunction

    // linear interpolation over the leading points of the discharge curve
    function pct_t percent_of(mv_t v);
      int n;
      int span;
      int lo_mv;
      int lo_pct;
      int hi_pct;
      n = (TABLE_POINTS > CURVE_LEN) ? CURVE_LEN : TABLE_POINTS;
      if (n < 2) n = 2;
      if (v >= CURVE_MV[0]) return CURVE_PCT[0];
      if (v <= CURVE_MV[n-1]) return CURVE_PCT[n-1];
      for (int i = 0; i + 1 < n; i++) begin
        if (v <= CURVE_MV[i] && v > CURVE_MV[i+1]) begin
          lo_mv  = int'(CURVE_MV[i+1]);
          lo_pct = int'(CURVE_PCT[i+1]);
          hi_pct = int'(CURVE_PCT[i]);
          span   = int'(CURVE_MV[i]) - lo_mv;
          if (span == 0) return CURVE_PCT[i+1];
          return pct_t'(lo_pct + ((int'(v) - lo_mv) * (hi_pct - lo_pct)) / span);
        end
      end
      return '0;
    endfunction

    function void note_sample(logic [PIN_W-1:0] pin);
      reading_t r;
      r.batt = scale_pin(pin);
      r.pct  = percent_of(r.batt);
      expected_readings.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_reading(mv_t batt, pct_t pct);
      reading_t r;
      if (expected_readings.size() == 0) begin
        report($sformatf("unexpected result batt=%0d pct=%0d", batt, pct));
      end else begin
        r = expected_readings.pop_front();
        if (batt !== r.batt)
          report($sformatf("battery_millivolts got %0d want %0d", batt, r.batt));
        if (pct !== r.pct)
          report($sformatf("charge_percent got %0d want %0d (batt %0d)",
                           pct, r.pct, r.batt));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [OHM_W-1:0]     cfg_wdata;

  bvcp_in_if  in_chan();
  bvcp_out_if out_chan();

  charge_scoreboard sb;
  int unsigned      samples_taken;
  bit               steady;
  bit               hold_done;
  int               hold_left;

  battery_voltage_to_charge_percent_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // clock
  always #HALF_PERIOD clk = ~clk;

  // watchdog
  initial begin
    #(2 * HALF_PERIOD * LIMIT_CYCLES);
    $display("Verification failed");
    $finish;
  end

  // transfer monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        sb.note_sample(in_chan.pin_millivolts);
        samples_taken <= samples_taken + 1;
      end
      if (out_chan.valid && out_chan.ready)
        sb.check_reading(out_chan.battery_millivolts, out_chan.charge_percent);
    end
  end

  // result side: random stalls, one long hold-off to back the pipe up
  initial begin
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && samples_taken >= 250) begin
        hold_done = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (steady) begin
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= 33);
      end
      @(posedge clk);
    end
  end

  // wait for the pipe to drain completely
  task wait_idle();
    while (sb.expected_readings.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [OHM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task set_divider(logic [OHM_W-1:0] full, logic [OHM_W-1:0] outr);
    in_chan.valid <= 1'b0;
    wait_idle();
    write_reg(REG_DIV_TOTAL, full);
    write_reg(REG_DIV_LOWER, outr);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // offer one sample, with a random gap ahead of it unless steady
  task send_sample(logic [PIN_W-1:0] pin);
    if (!steady) begin
      while ($urandom_range(99) < 33) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_chan.valid          <= 1'b1;
    in_chan.pin_millivolts <= pin;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // pin value that lands the battery voltage near the curve
  function logic [PIN_W-1:0] pick_pin();
    longint unsigned target;
    longint unsigned pin;
    if (sb.div_total == '0 || sb.div_lower == '0) return PIN_W'($urandom_range(4095));
    target = 64'($urandom_range(4250, 2950));
    pin = (target * sb.div_lower + sb.div_total - 1) / sb.div_total;
    if (pin > 4095) return PIN_W'($urandom_range(4095));
    return PIN_W'(pin);
  endfunction

  // stimulus
  initial begin
    logic [OHM_W-1:0] full;
    logic [OHM_W-1:0] outr;
    logic [PIN_W-1:0] edge_pins[$];

    sb = new();
    samples_taken = 0;
    steady        = 1'b0;
    hold_done     = 1'b0;
    hold_left     = 0;
    rst_n                  <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_index              <= '0;
    cfg_wdata              <= '0;
    in_chan.valid          <= 1'b0;
    in_chan.pin_millivolts <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed samples at the reset ratio of two: field extremes, full charge,
    // cutoff, curve knees and points just inside each boundary
    edge_pins = '{12'd0, 12'd4095, 12'd2100, 12'd2099, 12'd2075, 12'd2076,
                  12'd1500, 12'd1501, 12'd1540, 12'd1600, 12'd1625, 12'd1650,
                  12'd1675, 12'd1800, 12'd1913, 12'd1, 12'd2048, 12'd1024,
                  12'd3000, 12'd1599};
    foreach (edge_pins[i]) send_sample(edge_pins[i]);

    // random phases across divider settings
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin full = DIV_TOTAL_RST; outr = DIV_LOWER_RST;   end
        1: begin full = 20'hFFFFF;     outr = 20'd1;           end
        2: begin full = 20'd1;         outr = 20'hFFFFF;       end
        // zero full resistance forces zero volts
        3: begin full = 20'd0;         outr = 20'd100000;      end
        // zero output resistance saturates the battery voltage
        4: begin full = 20'd200000;    outr = 20'd0;           end
        5: begin full = 20'd100000;    outr = 20'd100000;      end
        6: begin full = 20'hFFFFF;     outr = 20'hFFFFF;       end
        9: begin
          full = OHM_W'($urandom_range(20'hFFFFF, 1));
          outr = OHM_W'($urandom_range(20'hFFFFF, 1));
        end
        default: begin
          outr = OHM_W'($urandom_range(262143, 1000));
          full = OHM_W'(outr * $urandom_range(3, 1) + $urandom_range(outr - 1, 0));
        end
      endcase
      set_divider(full, outr);
      steady = (ph == 6);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(99) < 75) send_sample(pick_pin());
        else send_sample(PIN_W'($urandom_range(4095)));
      end
      steady = 1'b0;
    end

    // drain and finish
    in_chan.valid <= 1'b0;
    while (sb.expected_readings.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/bvcp_pkg.sv
sv/bvcp_in_if.sv
sv/bvcp_out_if.sv
sv/bvcp_div_pipe.sv
sv/bvcp_interp.sv
sv/battery_voltage_to_charge_percent_core.sv
sv/bvcp_checker.sv
bench/tb.sv
